// ----- rtl/mcpi_pkg.sv -----
package mcpi_pkg;

   localparam int unsigned CurrentLimitDef = 655360;
   localparam int unsigned CommandLimitDef = 655360;
   localparam int unsigned OutputSatDef    = 655360;

   localparam logic signed [31:0] ONE_Q        = 32'sd65536;
   localparam logic signed [31:0] NEG_ONE_Q    = -32'sd65536;
   localparam logic signed [31:0] OFFSET_LIMIT = 32'sd39321;
   localparam logic signed [31:0] MAX32        = 32'sh7fffffff;
   localparam logic signed [31:0] MIN32        = 32'sh80000000;

   // register addresses (byte address / 4)
   localparam logic [2:0] REG_PROP  = 3'd0;
   localparam logic [2:0] REG_INTEG = 3'd1;
   localparam logic [2:0] REG_SENS  = 3'd2;
   localparam logic [2:0] REG_BEMF  = 3'd3;
   localparam logic [2:0] REG_DZAMP = 3'd4;
   localparam logic [2:0] REG_DZBND = 3'd5;
   localparam logic [2:0] REG_OUTG  = 3'd6;
   localparam logic [2:0] REG_CALIB = 3'd7;

   // datapath operations, one per sequencer step
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAL_SUB,     // t = raw - off (wide)
      OP_CAL_DIV,     // divider step
      OP_CAL_ADD,     // off = sat(off + q)
      OP_CAL_CLR,     // clear test at end of calibration
      OP_TICK,        // tick count update, calib flag
      OP_REAL_MUL,    // real = (raw-off)*sg
      OP_LOW_MUL,     // low = (raw-llo)*sg
      OP_ERR,         // err = target - real
      OP_INT_MUL,     // acc += ki*err
      OP_P_MUL,       // sum += kp*err
      OP_OFF_MUL,     // sum += sg*off
      OP_BEMF_MUL,    // sum += kb*speed
      OP_U,           // u = sat(sum)
      OP_COEF,        // e = u - low, start coeff
      OP_DZ_DIV,      // divider step
      OP_DZ_MUL,      // u = sat(u + coeff*amp)
      OP_STOP,        // zero when stopped or calibrating
      OP_OUT_MUL,     // stop test, safe = clamp(u*og)
      OP_CLEAR        // clear command
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAL_DIV,
      ST_RUN,
      ST_DZ_DIV,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef struct packed {
      op_type     op;
      logic       load_in;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic       div_done;
      logic       do_cal_div;
      logic       do_dz_div;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = MAX32;
      else if (v < -66'sd2147483648) r = MIN32;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ----- rtl/motor_current_pi_controller_top.sv -----
// Sequence: a clear command passes from acceptance to the output state, where its
// result loads; a control tick steps through the sequencer ops, running the
// calibration divider during calibration and the dead-zone ramp divider when the
// error lies inside a nonzero band. One item at a time; the next item is taken
// the cycle after the result loads, unless the waiting result is stalled.
// Synchronous active-high reset clears state and returns gains to their defaults.
module motor_current_pi_controller_top #(
   parameter int unsigned CURRENT_LIMIT     = mcpi_pkg::CurrentLimitDef,
   parameter int unsigned COMMAND_LIMIT     = mcpi_pkg::CommandLimitDef,
   parameter int unsigned OUTPUT_SATURATION = mcpi_pkg::OutputSatDef
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic signed [31:0] req_current_target,
   input  logic signed [31:0] req_current_raw,
   input  logic signed [31:0] req_joint_speed,
   input  logic signed [31:0] req_low_level_offset,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_drive_safe,
   output logic signed [31:0] rsp_drive_raw,
   output logic signed [31:0] rsp_current_real,
   output logic signed [31:0] rsp_current_error,
   output logic               rsp_estop,
   output logic               rsp_calibrating,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic signed [31:0] kp, ki, sg, kb, amp, og;
   logic [30:0]        band;
   logic [15:0]        cal;
   mcpi_pkg::cmd_type    cmd;
   mcpi_pkg::status_type status;

   assign csr_pready = 1'b1;

   mcpi_regs u_regs (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .prop_gain(kp), .integ_gain(ki), .sensor_gain(sg), .bemf_gain(kb),
      .dead_zone_amp(amp), .dead_zone_band(band), .out_gain(og), .calib_ticks(cal)
   );

   mcpi_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_cmd, .req_stall, .rsp_valid, .rsp_stall,
      .status, .cmd
   );

   mcpi_datapath #(
      .CURRENT_LIMIT(CURRENT_LIMIT), .COMMAND_LIMIT(COMMAND_LIMIT),
      .OUTPUT_SATURATION(OUTPUT_SATURATION)
   ) u_dp (
      .clock, .reset, .cmd, .status,
      .prop_gain(kp), .integ_gain(ki), .sensor_gain(sg), .bemf_gain(kb),
      .dead_zone_amp(amp), .dead_zone_band(band), .out_gain(og), .calib_ticks(cal),
      .in_target(req_current_target), .in_raw(req_current_raw),
      .in_speed(req_joint_speed), .in_llo(req_low_level_offset),
      .drive_safe(rsp_drive_safe), .drive_raw(rsp_drive_raw),
      .current_real(rsp_current_real), .current_error(rsp_current_error),
      .estop(rsp_estop), .calibrating(rsp_calibrating)
   );

endmodule

// ----- rtl/mcpi_datapath.sv -----
module mcpi_datapath #(
   parameter int unsigned CURRENT_LIMIT     = mcpi_pkg::CurrentLimitDef,
   parameter int unsigned COMMAND_LIMIT     = mcpi_pkg::CommandLimitDef,
   parameter int unsigned OUTPUT_SATURATION = mcpi_pkg::OutputSatDef
) (
   input  logic                clock,
   input  logic                reset,
   input  mcpi_pkg::cmd_type   cmd,
   output mcpi_pkg::status_type status,
   // configuration
   input  logic signed [31:0]  prop_gain,
   input  logic signed [31:0]  integ_gain,
   input  logic signed [31:0]  sensor_gain,
   input  logic signed [31:0]  bemf_gain,
   input  logic signed [31:0]  dead_zone_amp,
   input  logic [30:0]         dead_zone_band,
   input  logic signed [31:0]  out_gain,
   input  logic [15:0]         calib_ticks,
   // item
   input  logic signed [31:0]  in_target,
   input  logic signed [31:0]  in_raw,
   input  logic signed [31:0]  in_speed,
   input  logic signed [31:0]  in_llo,
   output logic signed [31:0]  drive_safe,
   output logic signed [31:0]  drive_raw,
   output logic signed [31:0]  current_real,
   output logic signed [31:0]  current_error,
   output logic                estop,
   output logic                calibrating
);

   localparam logic signed [33:0] CurLim = 34'(CURRENT_LIMIT);
   localparam logic signed [33:0] CmdLim = 34'(COMMAND_LIMIT);
   localparam logic signed [31:0] OutSat = 32'(OUTPUT_SATURATION);

   // architectural state
   logic signed [31:0] acc_ff, acc_in;
   logic signed [31:0] off_ff, off_in;
   logic [16:0]        tick_ff, tick_in;
   logic               stop_ff, stop_in;

   // item registers
   logic signed [31:0] tgt_ff, raw_ff, spd_ff, llo_ff;
   logic signed [31:0] real_ff, low_ff, err_ff, u_ff, e_ff;
   logic signed [34:0] sum_ff;
   logic               calib_ff;

   // shared multiplier: operands selected by op, product registered
   logic signed [31:0] ma, mb;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] mq;

   // divider: magnitude restoring, 48-bit numerator, 32-bit divisor
   logic [47:0] dnum_ff, dnum_in;
   logic [32:0] drem_ff, drem_in;
   logic [31:0] dden_ff, dden_in;
   logic        dneg_ff, dneg_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic [33:0] dtrial;

   // output registers
   logic signed [31:0] osafe_ff, osafe_in, oraw_ff, oraw_in;
   logic signed [31:0] oreal_ff, oreal_in, oerr_ff, oerr_in;
   logic               oest_ff, oest_in, ocal_ff, ocal_in;

   // working copies
   logic signed [31:0] real_in, low_in, err_in, u_in, e_in;
   logic signed [34:0] sum_in;
   logic               calib_in;
   logic signed [32:0] wdiff;
   logic signed [31:0] qsigned;
   logic signed [33:0] abs_real, abs_u;
   logic signed [31:0] band_s;
   logic signed [32:0] dz_add;
   logic signed [31:0] coef_cur;

   // floor-shifted, saturated Q16.16 product of the registered product
   assign mq = mcpi_pkg::sat32(66'(prod_ff >>> 16));

   // dead-zone coefficient from the error and the ramp quotient
   always_comb begin
      if (e_ff > band_s) coef_cur = mcpi_pkg::ONE_Q;
      else if (e_ff < -band_s) coef_cur = mcpi_pkg::NEG_ONE_Q;
      else if (band_s == '0) coef_cur = '0;
      else coef_cur = qsigned;
   end

   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.op)
         mcpi_pkg::OP_REAL_MUL: begin
            ma = mcpi_pkg::sat32(66'(raw_ff) - 66'(off_ff)); mb = sensor_gain;
         end
         mcpi_pkg::OP_LOW_MUL: begin
            ma = mcpi_pkg::sat32(66'(raw_ff) - 66'(llo_ff)); mb = sensor_gain;
         end
         mcpi_pkg::OP_INT_MUL: begin ma = integ_gain; mb = err_ff; end
         mcpi_pkg::OP_P_MUL: begin ma = prop_gain; mb = err_ff; end
         mcpi_pkg::OP_OFF_MUL: begin ma = sensor_gain; mb = off_ff; end
         mcpi_pkg::OP_BEMF_MUL: begin ma = bemf_gain; mb = spd_ff; end
         mcpi_pkg::OP_DZ_MUL: begin ma = coef_cur; mb = dead_zone_amp; end
         mcpi_pkg::OP_STOP: begin ma = u_in; mb = out_gain; end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   assign prod_in = ma * mb;
   assign dtrial  = {drem_ff, dnum_ff[47]} - {2'b00, dden_ff};
   assign qsigned = dneg_ff ? -$signed(dnum_ff[31:0]) : $signed(dnum_ff[31:0]);
   assign wdiff   = 33'(raw_ff) - 33'(off_ff);
   assign abs_real = real_ff < 0 ? -34'(real_ff) : 34'(real_ff);
   assign abs_u    = u_ff < 0 ? -34'(u_ff) : 34'(u_ff);
   assign band_s   = {1'b0, dead_zone_band};

   assign status.div_done   = (dcnt_ff == '0);
   assign status.do_cal_div = (calib_ticks != '0) && (tick_ff < 17'(calib_ticks));
   assign status.do_dz_div  = !(e_ff > band_s) && !(e_ff < -band_s) && (band_s != '0);

   always_comb begin
      acc_in = acc_ff; off_in = off_ff; tick_in = tick_ff; stop_in = stop_ff;
      real_in = real_ff; low_in = low_ff; err_in = err_ff; u_in = u_ff; e_in = e_ff;
      sum_in = sum_ff; calib_in = calib_ff;
      dnum_in = dnum_ff; drem_in = drem_ff; dden_in = dden_ff; dneg_in = dneg_ff;
      dcnt_in = dcnt_ff;
      osafe_in = osafe_ff; oraw_in = oraw_ff; oreal_in = oreal_ff; oerr_in = oerr_ff;
      oest_in = oest_ff; ocal_in = ocal_ff;
      dz_add = '0;

      // shared divider iteration
      if ((cmd.op == mcpi_pkg::OP_CAL_DIV || cmd.op == mcpi_pkg::OP_DZ_DIV)
          && dcnt_ff != '0) begin
         if (!dtrial[33]) begin
            drem_in = dtrial[32:0];
            dnum_in = {dnum_ff[46:0], 1'b1};
         end else begin
            drem_in = {drem_ff[31:0], dnum_ff[47]};
            dnum_in = {dnum_ff[46:0], 1'b0};
         end
         dcnt_in = dcnt_ff - 6'd1;
      end

      case (cmd.op)
         // divide (raw - off) by n + 1
         mcpi_pkg::OP_CAL_SUB: begin
            dneg_in = wdiff[32];
            dnum_in = 48'(wdiff[32] ? -wdiff : wdiff);
            dden_in = 32'(tick_ff) + 32'd1;
            drem_in = '0;
            dcnt_in = 6'd48;
         end
         mcpi_pkg::OP_CAL_ADD: begin
            off_in = mcpi_pkg::sat32(66'(off_ff) + 66'(qsigned));
         end
         mcpi_pkg::OP_CAL_CLR: begin
            if (calib_ticks != '0 && tick_ff == 17'(calib_ticks)
                && (off_ff > mcpi_pkg::OFFSET_LIMIT || off_ff < -mcpi_pkg::OFFSET_LIMIT))
               off_in = '0;
         end
         mcpi_pkg::OP_TICK: begin
            if (tick_ff <= 17'(calib_ticks)) tick_in = tick_ff + 17'd1;
            calib_in = ((tick_ff <= 17'(calib_ticks)) ? tick_ff + 17'd1 : tick_ff)
                       < 17'(calib_ticks);
         end
         mcpi_pkg::OP_REAL_MUL: ;
         mcpi_pkg::OP_LOW_MUL: real_in = mq;
         mcpi_pkg::OP_ERR: begin
            low_in = mq;
            err_in = mcpi_pkg::sat32(66'(tgt_ff) - 66'(real_ff));
         end
         mcpi_pkg::OP_INT_MUL: ;
         mcpi_pkg::OP_P_MUL: begin
            acc_in = mcpi_pkg::sat32(66'(acc_ff) + 66'(mq));
            sum_in = 35'(tgt_ff) + 35'(mcpi_pkg::sat32(66'(acc_ff) + 66'(mq)));
         end
         mcpi_pkg::OP_OFF_MUL, mcpi_pkg::OP_BEMF_MUL: sum_in = sum_ff + 35'(mq);
         mcpi_pkg::OP_U: begin
            sum_in = sum_ff + 35'(mq);
            u_in = mcpi_pkg::sat32(66'(sum_ff + 35'(mq)));
         end
         mcpi_pkg::OP_COEF: begin
            e_in = mcpi_pkg::sat32(66'(u_ff) - 66'(low_ff));
         end
         mcpi_pkg::OP_DZ_DIV: begin
            // set up on first entry: done flag set (count at zero) and numerator not loaded
            if (dcnt_ff == '0) begin
               dneg_in = e_ff[31];
               dnum_in = {(e_ff[31] ? 32'(-33'(e_ff)) : 32'(e_ff)), 16'd0};
               dden_in = {1'b0, dead_zone_band};
               drem_in = '0;
               dcnt_in = 6'd48;
            end
         end
         mcpi_pkg::OP_DZ_MUL: ;
         mcpi_pkg::OP_STOP: begin
            dz_add = 33'(u_ff) + 33'(mq);
            u_in = mcpi_pkg::sat32(66'(dz_add));
            if (stop_ff || calib_ff) u_in = '0;
         end
         mcpi_pkg::OP_OUT_MUL: begin
            if (abs_real > CurLim || abs_u > CmdLim) stop_in = 1'b1;
            oraw_in  = u_ff;
            oreal_in = real_ff;
            oerr_in  = mcpi_pkg::sat32(66'(u_ff) - 66'(real_ff));
            oest_in  = stop_in;
            ocal_in  = calib_ff;
            if (mq > OutSat) osafe_in = OutSat;
            else if (mq < -OutSat) osafe_in = -OutSat;
            else osafe_in = mq;
            if (stop_in || calib_ff) osafe_in = '0;
         end
         mcpi_pkg::OP_CLEAR: begin
            acc_in = '0;
            osafe_in = '0; oraw_in = '0; oreal_in = '0; oerr_in = '0;
            oest_in = stop_ff;
            ocal_in = tick_ff < 17'(calib_ticks);
         end
         default: ;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0; off_ff <= '0; tick_ff <= '0; stop_ff <= 1'b0; dcnt_ff <= '0;
      end else begin
         acc_ff <= acc_in; off_ff <= off_in; tick_ff <= tick_in; stop_ff <= stop_in;
         dcnt_ff <= dcnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         tgt_ff <= in_target; raw_ff <= in_raw; spd_ff <= in_speed; llo_ff <= in_llo;
      end
      prod_ff <= prod_in;
      real_ff <= real_in; low_ff <= low_in; err_ff <= err_in; u_ff <= u_in; e_ff <= e_in;
      sum_ff <= sum_in; calib_ff <= calib_in;
      dnum_ff <= dnum_in; drem_ff <= drem_in; dden_ff <= dden_in; dneg_ff <= dneg_in;
      if (cmd.out_load) begin
         osafe_ff <= osafe_in; oraw_ff <= oraw_in; oreal_ff <= oreal_in;
         oerr_ff <= oerr_in; oest_ff <= oest_in; ocal_ff <= ocal_in;
      end
   end

   assign drive_safe    = osafe_ff;
   assign drive_raw     = oraw_ff;
   assign current_real  = oreal_ff;
   assign current_error = oerr_ff;
   assign estop         = oest_ff;
   assign calibrating   = ocal_ff;

endmodule

// ----- rtl/mcpi_ctrl.sv -----
module mcpi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_cmd,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  mcpi_pkg::status_type status,
   output mcpi_pkg::cmd_type    cmd
);

   mcpi_pkg::state_type state_ff, state_in;
   mcpi_pkg::op_type    step_ff, step_in;
   logic                valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcpi_pkg::ST_IDLE;
         step_ff  <= mcpi_pkg::OP_NONE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

   // sequencer: at most one datapath op per cycle; none while idle
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      valid_in = valid_ff && rsp_stall;
      cmd      = '{op: mcpi_pkg::OP_NONE, load_in: 1'b0, out_load: 1'b0};
      // accept only when the result register is free or leaving
      req_stall = !(state_ff == mcpi_pkg::ST_IDLE && !(valid_ff && rsp_stall));
      case (state_ff)
         mcpi_pkg::ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load_in = 1'b1;
               if (req_cmd) begin
                  state_in = mcpi_pkg::ST_OUT;
                  step_in  = mcpi_pkg::OP_CLEAR;
               end else begin
                  state_in = mcpi_pkg::ST_RUN;
                  step_in  = mcpi_pkg::OP_CAL_SUB;
               end
            end
         end
         mcpi_pkg::ST_RUN: begin
            cmd.op = step_ff;
            case (step_ff)
               mcpi_pkg::OP_CAL_SUB: begin
                  if (status.do_cal_div) begin
                     state_in = mcpi_pkg::ST_CAL_DIV;
                     step_in  = mcpi_pkg::OP_CAL_DIV;
                  end else begin
                     cmd.op  = mcpi_pkg::OP_CAL_CLR;
                     step_in = mcpi_pkg::OP_TICK;
                  end
               end
               mcpi_pkg::OP_CAL_ADD: step_in = mcpi_pkg::OP_TICK;
               mcpi_pkg::OP_TICK: step_in = mcpi_pkg::OP_REAL_MUL;
               mcpi_pkg::OP_REAL_MUL: step_in = mcpi_pkg::OP_LOW_MUL;
               mcpi_pkg::OP_LOW_MUL: step_in = mcpi_pkg::OP_ERR;
               mcpi_pkg::OP_ERR: step_in = mcpi_pkg::OP_INT_MUL;
               mcpi_pkg::OP_INT_MUL: step_in = mcpi_pkg::OP_P_MUL;
               mcpi_pkg::OP_P_MUL: step_in = mcpi_pkg::OP_OFF_MUL;
               mcpi_pkg::OP_OFF_MUL: step_in = mcpi_pkg::OP_BEMF_MUL;
               mcpi_pkg::OP_BEMF_MUL: step_in = mcpi_pkg::OP_U;
               mcpi_pkg::OP_U: step_in = mcpi_pkg::OP_COEF;
               mcpi_pkg::OP_COEF: begin
                  state_in = mcpi_pkg::ST_DZ_DIV;
                  step_in  = mcpi_pkg::OP_DZ_DIV;
               end
               default: state_in = mcpi_pkg::ST_IDLE;
            endcase
         end
         mcpi_pkg::ST_CAL_DIV: begin
            cmd.op = mcpi_pkg::OP_CAL_DIV;
            if (status.div_done) begin
               state_in = mcpi_pkg::ST_RUN;
               step_in  = mcpi_pkg::OP_CAL_ADD;
               cmd.op   = mcpi_pkg::OP_NONE;
            end
         end
         mcpi_pkg::ST_DZ_DIV: begin
            // first cycle loads the divider; skip it when no ramp needed
            if (step_ff == mcpi_pkg::OP_DZ_DIV) begin
               if (status.do_dz_div) cmd.op = mcpi_pkg::OP_DZ_DIV;
               step_in = mcpi_pkg::OP_NONE;
               if (!status.do_dz_div) state_in = mcpi_pkg::ST_FINISH;
            end else begin
               cmd.op = mcpi_pkg::OP_DZ_DIV;
               if (status.div_done) begin
                  cmd.op   = mcpi_pkg::OP_NONE;
                  state_in = mcpi_pkg::ST_FINISH;
               end
            end
            if (state_in == mcpi_pkg::ST_FINISH) step_in = mcpi_pkg::OP_DZ_MUL;
         end
         mcpi_pkg::ST_FINISH: begin
            cmd.op = step_ff;
            case (step_ff)
               mcpi_pkg::OP_DZ_MUL: step_in = mcpi_pkg::OP_STOP;
               mcpi_pkg::OP_STOP: begin
                  state_in = mcpi_pkg::ST_OUT;
                  step_in  = mcpi_pkg::OP_OUT_MUL;
               end
               default: state_in = mcpi_pkg::ST_IDLE;
            endcase
         end
         mcpi_pkg::ST_OUT: begin
            cmd.op       = step_ff;
            cmd.out_load = 1'b1;
            valid_in     = 1'b1;
            state_in     = mcpi_pkg::ST_IDLE;
         end
         default: state_in = mcpi_pkg::ST_IDLE;
      endcase
   end

endmodule

// ----- rtl/mcpi_regs.sv -----
module mcpi_regs (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic signed [31:0] prop_gain,
   output logic signed [31:0] integ_gain,
   output logic signed [31:0] sensor_gain,
   output logic signed [31:0] bemf_gain,
   output logic signed [31:0] dead_zone_amp,
   output logic [30:0]        dead_zone_band,
   output logic signed [31:0] out_gain,
   output logic [15:0]        calib_ticks
);

   logic signed [31:0] kp_ff, ki_ff, sg_ff, kb_ff, amp_ff, og_ff;
   logic [30:0]        band_ff;
   logic [15:0]        cal_ff;
   logic [2:0]         idx;

   assign idx = csr_paddr[4:2];

   // register writes on the access beat
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '0; ki_ff <= '0; sg_ff <= mcpi_pkg::ONE_Q; kb_ff <= '0; amp_ff <= '0;
         band_ff <= 31'd65536; og_ff <= mcpi_pkg::ONE_Q; cal_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (idx)
            mcpi_pkg::REG_PROP:  kp_ff   <= csr_pwdata;
            mcpi_pkg::REG_INTEG: ki_ff   <= csr_pwdata;
            mcpi_pkg::REG_SENS:  sg_ff   <= csr_pwdata;
            mcpi_pkg::REG_BEMF:  kb_ff   <= csr_pwdata;
            mcpi_pkg::REG_DZAMP: amp_ff  <= csr_pwdata;
            mcpi_pkg::REG_DZBND: band_ff <= csr_pwdata[30:0];
            mcpi_pkg::REG_OUTG:  og_ff   <= csr_pwdata;
            mcpi_pkg::REG_CALIB: cal_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (idx)
         mcpi_pkg::REG_PROP:  csr_prdata = kp_ff;
         mcpi_pkg::REG_INTEG: csr_prdata = ki_ff;
         mcpi_pkg::REG_SENS:  csr_prdata = sg_ff;
         mcpi_pkg::REG_BEMF:  csr_prdata = kb_ff;
         mcpi_pkg::REG_DZAMP: csr_prdata = amp_ff;
         mcpi_pkg::REG_DZBND: csr_prdata = {1'b0, band_ff};
         mcpi_pkg::REG_OUTG:  csr_prdata = og_ff;
         mcpi_pkg::REG_CALIB: csr_prdata = {16'd0, cal_ff};
         default: csr_prdata = '0;
      endcase
   end

   assign prop_gain = kp_ff; assign integ_gain = ki_ff; assign sensor_gain = sg_ff;
   assign bemf_gain = kb_ff; assign dead_zone_amp = amp_ff; assign dead_zone_band = band_ff;
   assign out_gain = og_ff; assign calib_ticks = cal_ff;

endmodule

// ----- rtl/mcpi_checker.sv -----
module mcpi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_drive_safe,
   input logic        rsp_estop,
   input logic        rsp_calibrating
);

   // a waiting result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive_safe))
      else $error("result changed while stalled");

   // no new item while a result is blocked
   a_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output blocked");

   // drive is zero when stopped or calibrating
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_estop || rsp_calibrating) |-> rsp_drive_safe == '0)
      else $error("drive not zero while stopped");

   // estop stays latched from one result to the next
   a_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_estop |=> !rsp_valid || rsp_estop)
      else $error("estop released");

endmodule

bind motor_current_pi_controller_top mcpi_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_drive_safe, .rsp_estop, .rsp_calibrating
);

// ----- sim/tb_motor_current_pi_controller_top.sv -----
module tb_motor_current_pi_controller_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CUR_LIM   = 655360;
   localparam longint CMD_LIM   = 655360;
   localparam longint OUT_SAT   = 655360;
   localparam longint UNITY     = 65536;
   localparam longint OFS_CLEAR = 39321;
   localparam int     CYCLE_LIMIT = 1000000;
   localparam int     HOLD_LEN  = 400;

   typedef enum logic {CMD_TICK = 1'b0, CMD_CLR_INT = 1'b1} beat_cmd_type;

   typedef struct {
      beat_cmd_type cmd;
      int        target;
      int        raw;
      int        speed;
      int        llo;
   } tick_in_type;

   typedef struct {
      int   safe;
      int   drive;
      int   real_i;
      int   err;
      logic estop;
      logic calib;
   } drive_out_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic               req_cmd = 0;
   logic signed [31:0] req_current_target = 0;
   logic signed [31:0] req_current_raw = 0;
   logic signed [31:0] req_joint_speed = 0;
   logic signed [31:0] req_low_level_offset = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [31:0] rsp_drive_safe;
   logic signed [31:0] rsp_drive_raw;
   logic signed [31:0] rsp_current_real;
   logic signed [31:0] rsp_current_error;
   logic               rsp_estop;
   logic               rsp_calibrating;
   logic               csr_psel = 0;
   logic               csr_penable = 0;
   logic               csr_pwrite = 0;
   logic [4:0]         csr_paddr = 0;
   logic [31:0]        csr_pwdata = 0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   motor_current_pi_controller_top u_top (.*);

   // controller shadow: gains and state
   longint kp, ki, sg, kb, dz_amp, og;
   longint dz_band, cal_len;
   longint acc, ofs;
   longint ticks;
   bit     stopped;

   tick_in_type   pending_q[$];
   drive_out_type drive_exp_q[$];
   int         errors = 0;
   int         cycles = 0;
   bit         req_fired = 0, rsp_fired = 0;
   bit         calm = 0;
   bit         hold_go = 0, hold_done = 0;
   int         hold_left = 0;
   int         send_gap = 0, rcv_wait = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Q16.16 product, floor shift
   function automatic longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      return sat32(p >>> 16);
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic drive_out_type run_tick(tick_in_type t);
      drive_out_type r;
      longint tgt, raw, spd, llo, rl, lw, er, u, e, cf, sf;
      longint n;
      bit     cal;
      tgt = t.target; raw = t.raw; spd = t.speed; llo = t.llo;
      n = ticks;
      if (t.cmd == CMD_CLR_INT) begin
         acc = 0;
         r.safe = 0; r.drive = 0; r.real_i = 0; r.err = 0;
         r.estop = stopped;
         r.calib = ticks < cal_len;
         return r;
      end
      // offset calibration: running mean, then clear if too large
      if (cal_len > 0) begin
         if (n < cal_len) ofs = sat32(ofs + (raw - ofs) / (n + 1));
         else if (n == cal_len && mag(ofs) > OFS_CLEAR) ofs = 0;
      end
      if (n <= cal_len) ticks = n + 1;
      cal = ticks < cal_len;
      rl = qmul(sat32(raw - ofs), sg);
      lw = qmul(sat32(raw - llo), sg);
      er = sat32(tgt - rl);
      acc = sat32(acc + qmul(ki, er));
      u = sat32(tgt + acc + qmul(kp, er) + qmul(sg, ofs) + qmul(kb, spd));
      // dead-zone ramp
      e = sat32(u - lw);
      if (e > dz_band) cf = UNITY;
      else if (e < -dz_band) cf = -UNITY;
      else if (dz_band == 0) cf = 0;
      else cf = (e * UNITY) / dz_band;
      u = sat32(u + qmul(cf, dz_amp));
      if (stopped || cal) u = 0;
      if (mag(rl) > CUR_LIM || mag(u) > CMD_LIM) stopped = 1;
      sf = qmul(u, og);
      if (sf > OUT_SAT) sf = OUT_SAT;
      else if (sf < -OUT_SAT) sf = -OUT_SAT;
      if (stopped || cal) sf = 0;
      r.safe = int'(sf); r.drive = int'(u); r.real_i = int'(rl);
      r.err = int'(sat32(u - rl)); r.estop = stopped; r.calib = cal;
      return r;
   endfunction

   function automatic int idle_draw();
      return calm ? 0 : int'($urandom_range(0, 12));
   endfunction

   // handshake sampling, prediction and result check
   always @(posedge clock) begin
      drive_out_type x;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      req_fired = !reset && req_valid && !req_stall;
      rsp_fired = !reset && rsp_valid && !rsp_stall;
      if (req_fired) begin
         tick_in_type t;
         t.cmd = beat_cmd_type'(req_cmd); t.target = req_current_target;
         t.raw = req_current_raw; t.speed = req_joint_speed; t.llo = req_low_level_offset;
         drive_exp_q.push_back(run_tick(t));
      end
      if (rsp_fired) begin
         if (drive_exp_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat drive_safe %0d", $time, rsp_drive_safe);
         end else begin
            x = drive_exp_q.pop_front();
            if (rsp_drive_safe !== x.safe) begin
               errors++;
               $display("%0t: drive_safe exp %0d got %0d", $time, x.safe, rsp_drive_safe);
            end
            if (rsp_drive_raw !== x.drive) begin
               errors++;
               $display("%0t: drive_raw exp %0d got %0d", $time, x.drive, rsp_drive_raw);
            end
            if (rsp_current_real !== x.real_i) begin
               errors++;
               $display("%0t: current_real exp %0d got %0d", $time, x.real_i,
                        rsp_current_real);
            end
            if (rsp_current_error !== x.err) begin
               errors++;
               $display("%0t: current_error exp %0d got %0d", $time, x.err,
                        rsp_current_error);
            end
            if (rsp_estop !== x.estop) begin
               errors++;
               $display("%0t: estop exp %0b got %0b", $time, x.estop, rsp_estop);
            end
            if (rsp_calibrating !== x.calib) begin
               errors++;
               $display("%0t: calibrating exp %0b got %0b", $time, x.calib,
                        rsp_calibrating);
            end
         end
      end
   end

   // sender: one beat at a time from the pending queue
   always @(negedge clock) begin
      logic     v;
      tick_in_type t;
      v = req_valid;
      if (req_fired) v = 0;
      if (!v && !reset) begin
         if (send_gap > 0) send_gap--;
         else if (pending_q.size() > 0) begin
            t = pending_q.pop_front();
            req_cmd <= t.cmd;
            req_current_target <= t.target;
            req_current_raw <= t.raw;
            req_joint_speed <= t.speed;
            req_low_level_offset <= t.llo;
            v = 1;
            if ($urandom_range(0, 39) == 0) calm = ~calm;
            send_gap = idle_draw();
         end
      end
      req_valid <= v;
   end

   // receiver: random stall per beat, plus one long hold-off
   always @(negedge clock) begin
      logic s;
      if (hold_go && !hold_done) begin
         hold_left = HOLD_LEN;
         hold_done = 1;
      end
      if (rsp_fired) rcv_wait = idle_draw();
      if (hold_left > 0) begin
         hold_left--;
         s = 1;
      end else if (rcv_wait > 0) begin
         rcv_wait--;
         s = 1;
      end else s = 0;
      rsp_stall <= s;
   end

   task automatic csr_write(logic [2:0] idx, longint val);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val[31:0];
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         mcpi_pkg::REG_PROP:  kp = longint'(signed'(val[31:0]));
         mcpi_pkg::REG_INTEG: ki = longint'(signed'(val[31:0]));
         mcpi_pkg::REG_SENS:  sg = longint'(signed'(val[31:0]));
         mcpi_pkg::REG_BEMF:  kb = longint'(signed'(val[31:0]));
         mcpi_pkg::REG_DZAMP: dz_amp = longint'(signed'(val[31:0]));
         mcpi_pkg::REG_DZBND: dz_band = val & 64'h7fffffff;
         mcpi_pkg::REG_OUTG:  og = longint'(signed'(val[31:0]));
         default:   cal_len = val & 64'hffff;
      endcase
   endtask

   task automatic set_gains(longint p, longint i, longint s, longint b, longint a,
                            longint bd, longint o, longint c);
      csr_write(mcpi_pkg::REG_PROP, p);  csr_write(mcpi_pkg::REG_INTEG, i);
      csr_write(mcpi_pkg::REG_SENS, s);  csr_write(mcpi_pkg::REG_BEMF, b);
      csr_write(mcpi_pkg::REG_DZAMP, a); csr_write(mcpi_pkg::REG_DZBND, bd);
      csr_write(mcpi_pkg::REG_OUTG, o);  csr_write(mcpi_pkg::REG_CALIB, c);
   endtask

   task automatic push(beat_cmd_type c, int tg, int rw, int sp, int lo);
      tick_in_type t;
      t.cmd = c; t.target = tg; t.raw = rw; t.speed = sp; t.llo = lo;
      pending_q.push_back(t);
   endtask

   function automatic int near(int amp);
      return int'($urandom_range(0, 2 * amp)) - amp;
   endfunction

   // in-range ticks with occasional integrator clears and off-scale noise
   task automatic push_random(int count, int amp);
      beat_cmd_type c;
      for (int k = 0; k < count; k++) begin
         c = ($urandom_range(0, 9) == 0) ? CMD_CLR_INT : CMD_TICK;
         if ($urandom_range(0, 29) == 0)
            push(c, $urandom, $urandom, $urandom, $urandom);
         else
            push(c, near(amp), near(amp), near(amp), near(amp / 4));
      end
   endtask

   task automatic drain();
      wait (pending_q.size() == 0 && !req_valid && drive_exp_q.size() == 0);
      repeat (150) @(posedge clock);
   endtask

   initial begin
      kp = 0; ki = 0; sg = UNITY; kb = 0; dz_amp = 0; dz_band = UNITY; og = UNITY;
      cal_len = 0; acc = 0; ofs = 0; ticks = 0; stopped = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // calibration of four ticks, moderate gains
      set_gains(32768, 655, 65536, 6554, 3277, 65536, 65536, 4);
      push(CMD_CLR_INT, 0, 0, 0, 0);
      push(CMD_TICK, 65536, 20000, 0, 0);
      push(CMD_TICK, 65536, 30000, 0, 0);
      push(CMD_CLR_INT, 12345, 999, 1, 2);
      push(CMD_TICK, -65536, 40000, 1000, 500);
      push(CMD_TICK, 0, 50000, -1000, -500);
      // clearing test tick, then normal ticks
      push(CMD_TICK, 100000, 10000, 65536, 1000);
      push(CMD_TICK, -100000, -10000, -65536, 0);
      push(CMD_TICK, 3000, 2000, 0, 2000);
      push(CMD_CLR_INT, 0, 0, 0, 0);
      push(CMD_TICK, 70000, 0, 0, 0);
      push(CMD_TICK, -70000, 0, 0, 0);
      push_random(400, 200000);
      #1000;
      hold_go = 1;
      drain();

      // zero band, negative output gain, recalibration from present count
      set_gains(-20000, 1000, 78643, -30000, -65536, 0, -131072, 12);
      push_random(400, 150000);
      drain();

      // widest band, no calibration
      set_gains(100000, -2000, 50000, 100000, 200000, 32'h7fffffff, 40000, 0);
      push_random(400, 250000);
      drain();

      // longest calibration, outputs held at zero
      set_gains(65536, 0, 65536, 0, 0, 1, 65536, 65535);
      push_random(50, 300000);
      drain();

      // extremes: full-scale fields and gains, stop latches
      set_gains(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                32'h80000000, 32'h7fffffff, 32'h80000000, 0);
      push(CMD_TICK, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      push(CMD_TICK, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      push(CMD_TICK, 0, 32'h7fffffff, 32'h80000000, 0);
      push(CMD_CLR_INT, 32'h7fffffff, 32'h80000000, -1, -1);
      for (int k = 0; k < 300; k++)
         push(($urandom_range(0, 9) == 0) ? CMD_CLR_INT : CMD_TICK,
              $urandom, $urandom, $urandom, $urandom);
      drain();

      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
